FILE: src/rrs_pkg.sv
package rrs_pkg;

	// fixed field widths of the channels and the register port
	localparam int IDX_W      = 6;
	localparam int FIT_IN_W   = 16;
	localparam int RND_W      = 16;
	localparam int TOT_W      = 22;
	localparam int POP_SIZE_W = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [POP_SIZE_W-1:0] POP_SIZE_RESET = 7'd64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POP_SIZE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = 1'b1;

	// item command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	// selection modes
	localparam logic MODE_ROULETTE = 1'b0;
	localparam logic MODE_RANKED   = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic write;        // store fitness of the accepted item
		logic start;        // latch size, mode and fraction, clear total
		logic issue;        // read the entry at the walk pointer and advance
		logic acc_total;    // add returning weight into the total
		logic mul;          // wheel position = fraction * total
		logic restart;      // rewind the pointer, clear the running sum
		logic acc_partial;  // add returning weight into the running sum
		logic load_out;     // move the selection into the output register
	} rrs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_issue;   // pointer sits on the last active entry
		logic all_issued;   // pointer has passed the last active entry
		logic hit;          // returning entry ends the search
		logic out_free;     // output register can take a new result
	} rrs_status_t;

endpackage

FILE: src/rrs_in_if.sv
interface rrs_in_if;
	import rrs_pkg::*;

	logic                valid;
	logic                ready;
	logic                command;
	logic [IDX_W-1:0]    entry_index;
	logic [FIT_IN_W-1:0] fitness_value;
	logic [RND_W-1:0]    random_fraction;

	modport source (
		output valid, command, entry_index, fitness_value, random_fraction,
		input  ready
	);
	modport sink (
		input  valid, command, entry_index, fitness_value, random_fraction,
		output ready
	);
endinterface

FILE: src/rrs_out_if.sv
interface rrs_out_if;
	import rrs_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] selected_index;
	logic [TOT_W-1:0] total_weight;

	modport source (
		output valid, selected_index, total_weight,
		input  ready
	);
	modport sink (
		input  valid, selected_index, total_weight,
		output ready
	);
endinterface

FILE: src/rrs_ram.sv
module rrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: src/rrs_ctrl.sv
module rrs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_command,
	output logic                in_ready,
	input  rrs_pkg::rrs_status_t st,
	output rrs_pkg::rrs_cmd_t    cmd
);
	import rrs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DRAIN,
		ST_MUL,
		ST_SEARCH,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.write = accept && (in_command == CMD_WRITE);
				cmd.start = accept && (in_command == CMD_SELECT);
			end
			ST_SUM: begin
				cmd.issue     = 1'b1;
				cmd.acc_total = 1'b1;
			end
			ST_DRAIN: begin
				cmd.acc_total = 1'b1;
			end
			ST_MUL: begin
				cmd.mul     = 1'b1;
				cmd.restart = 1'b1;
			end
			ST_SEARCH: begin
				cmd.issue       = !st.all_issued && !st.hit;
				cmd.acc_partial = 1'b1;
			end
			ST_DONE: begin
				cmd.load_out = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (in_command == CMD_SELECT)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (st.last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (st.hit) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (st.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: src/rrs_datapath.sv
module rrs_datapath #(
	parameter int POP_MAX      = 64,
	parameter int FITNESS_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rrs_pkg::rrs_cmd_t              cmd,
	output rrs_pkg::rrs_status_t           st,
	input  logic [rrs_pkg::POP_SIZE_W-1:0] pop_size,
	input  logic                           select_mode,
	input  logic [rrs_pkg::IDX_W-1:0]      entry_index,
	input  logic [rrs_pkg::FIT_IN_W-1:0]   fitness_value,
	input  logic [rrs_pkg::RND_W-1:0]      random_fraction,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rrs_pkg::IDX_W-1:0]      selected_index,
	output logic [rrs_pkg::TOT_W-1:0]      total_weight
);
	import rrs_pkg::*;

	localparam int AW  = $clog2(POP_MAX);
	// counts hold both the register value and POP_MAX
	localparam int CW  = ($clog2(POP_MAX + 1) > POP_SIZE_W) ? $clog2(POP_MAX + 1) : POP_SIZE_W;
	localparam int TW  = FITNESS_BITS + CW;
	localparam int PW  = TW + RND_W;

	logic [CW-1:0]           n_act;
	logic [CW-1:0]           pop_ext;
	logic [CW-1:0]           n_q;
	logic                    mode_q;
	logic [RND_W-1:0]        r_q;
	logic [CW-1:0]           idx_q;
	logic [CW-1:0]           idx_s1;
	logic                    v_s1;
	logic [TW-1:0]           total_q;
	logic [TW-1:0]           partial_q;
	logic [TW-1:0]           partial_nx;
	logic [PW-1:0]           pos_q;
	logic [PW-1:0]           prod;
	logic [CW-1:0]           sel_q;
	logic [CW-1:0]           rank_w;
	logic [TW-1:0]           weight;
	logic [FITNESS_BITS-1:0] ram_rdata;
	logic                    ram_we;
	logic                    reach;
	logic                    out_valid_q;
	logic [IDX_W-1:0]        out_idx_q;
	logic [TOT_W-1:0]        out_tot_q;

	// zero reads as one, above the table saturates
	assign pop_ext = CW'(pop_size);
	always_comb begin
		if (pop_ext == '0) begin
			n_act = CW'(1);
		end else if (pop_ext > CW'(POP_MAX)) begin
			n_act = CW'(POP_MAX);
		end else begin
			n_act = pop_ext;
		end
	end

	// writes beyond the table are dropped
	assign ram_we = cmd.write && (CW'(entry_index) < CW'(POP_MAX));

	rrs_ram #(
		.WIDTH (FITNESS_BITS),
		.DEPTH (POP_MAX)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(entry_index)),
		.wdata (FITNESS_BITS'(fitness_value)),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign rank_w     = n_q - idx_s1;
	assign weight     = (mode_q == MODE_RANKED) ? TW'(rank_w) : TW'(ram_rdata);
	assign partial_nx = partial_q + weight;
	assign prod       = r_q * total_q;
	assign reach      = ({partial_nx, {RND_W{1'b0}}} >= pos_q) || (idx_s1 == n_q - CW'(1));

	assign st.last_issue = (idx_q == n_q - CW'(1));
	assign st.all_issued = (idx_q == n_q);
	assign st.hit        = v_s1 && reach;
	assign st.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			v_s1 <= cmd.issue;
			if (cmd.start || cmd.restart) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (cmd.start) begin
			n_q     <= n_act;
			mode_q  <= select_mode;
			r_q     <= random_fraction;
			total_q <= '0;
		end else if (cmd.acc_total && v_s1) begin
			total_q <= total_q + weight;
		end
		if (cmd.mul) begin
			pos_q <= prod;
		end
		if (cmd.restart) begin
			partial_q <= '0;
		end else if (cmd.acc_partial && v_s1) begin
			partial_q <= partial_nx;
			if (reach) begin
				sel_q <= idx_s1;
			end
		end
		if (cmd.load_out) begin
			out_idx_q <= IDX_W'(sel_q);
			out_tot_q <= TOT_W'(total_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign selected_index = out_idx_q;
	assign total_weight   = out_tot_q;
endmodule

FILE: src/roulette_and_rank_selector_core.sv
// roulette and rank selector
// cmd_ch carries items: a write item (command 0) stores fitness_value at
// entry_index, a select item (command 1) brings random_fraction r and yields
// one result on res_ch with the chosen index and the total weight.
// roulette mode weighs entry i by its fitness, ranked mode by n - i, n being
// the active count; the pick is the first entry whose running sum times 65536
// reaches r * total, else the last active one. pop_size and select_mode are to be
// set through the cfg_* write port while idle; the block does not enforce this.
// a write item leaves cmd_ch ready. a select item over n active entries runs
// from accept to result register as one pass of n table reads for the total,
// a drain step, a multiply, then a second read pass up to the hit; both
// passes go through the single read port of the fitness table.
// the result waits in an output register; when res_ch stalls, the block
// takes and finishes write items, and a select finishes its search and holds
// until the register frees up.
// reset returns to idle with pop_size 64 and roulette mode; the fitness
// table is not cleared and must be written before it is read.
module roulette_and_rank_selector_core #(
	parameter int POP_MAX      = 64,
	parameter int FITNESS_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rrs_in_if.sink                        cmd_ch,
	rrs_out_if.source                     res_ch,
	input  logic                          cfg_we,
	input  logic [rrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rrs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rrs_pkg::*;

	logic [POP_SIZE_W-1:0] pop_size_q;
	logic                  select_mode_q;
	rrs_cmd_t              cmd;
	rrs_status_t           st;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_size_q    <= POP_SIZE_RESET;
			select_mode_q <= MODE_ROULETTE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POP_SIZE: begin
					pop_size_q <= cfg_data[POP_SIZE_W-1:0];
				end
				REG_SELECT_MODE: begin
					select_mode_q <= cfg_data[0];
				end
				default: begin
					pop_size_q <= pop_size_q;
				end
			endcase
		end
	end

	// sequencer: idle, total pass, drain, multiply, search pass, hand-off
	rrs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd_ch.valid),
		.in_command (cmd_ch.command),
		.in_ready   (cmd_ch.ready),
		.st         (st),
		.cmd        (cmd)
	);

	// table, accumulators, wheel position and output register
	rrs_datapath #(
		.POP_MAX      (POP_MAX),
		.FITNESS_BITS (FITNESS_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.pop_size        (pop_size_q),
		.select_mode     (select_mode_q),
		.entry_index     (cmd_ch.entry_index),
		.fitness_value   (cmd_ch.fitness_value),
		.random_fraction (cmd_ch.random_fraction),
		.out_valid       (res_ch.valid),
		.out_ready       (res_ch.ready),
		.selected_index  (res_ch.selected_index),
		.total_weight    (res_ch.total_weight)
	);
endmodule

FILE: src/rrs_checker.sv
module rrs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          in_command,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [rrs_pkg::IDX_W-1:0]     out_index,
	input logic [rrs_pkg::TOT_W-1:0]     out_total
);
	import rrs_pkg::*;

	// a select item closes the input for its search
	a_select_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_command == CMD_SELECT) |=> !in_ready)
		else $error("input still ready after a select item");

	// a write item never blocks the next one
	a_write_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_command == CMD_WRITE) |=> in_ready)
		else $error("input blocked after a write item");

	// a result only appears at the end of a search
	a_result_from_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

	// stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_total))
		else $error("stalled result changed");
endmodule

bind roulette_and_rank_selector_core rrs_checker u_rrs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (cmd_ch.valid),
	.in_ready   (cmd_ch.ready),
	.in_command (cmd_ch.command),
	.out_valid  (res_ch.valid),
	.out_ready  (res_ch.ready),
	.out_index  (res_ch.selected_index),
	.out_total  (res_ch.total_weight)
);
